// File: rtl/ffcam_pkg.sv
// Package: shared types, constants and the CORDIC angle table of the camera block.
`default_nettype none
package ffcam_pkg;

    // Event kinds.
    localparam logic [1:0] CMD_POINTER = 2'd0;
    localparam logic [1:0] CMD_WHEEL   = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MOVE_SPEED = 2'd0;
    localparam logic [1:0] CFG_MOUSE_GAIN = 2'd1;
    localparam logic [1:0] CFG_DRIFT_HOLD = 2'd2;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_TAB_LEN    = 24;

    // Reset values of the configuration registers.
    localparam logic [11:0] SPEED_RST = 12'd50;
    localparam logic [9:0]  GAIN_RST  = 10'd205;
    localparam logic [15:0] HOLD_RST  = 16'd6554;

    // Angle constants in 1/256 degree.
    localparam int YAW_FULL     = 92160;
    localparam int YAW_HALF     = 46080;
    localparam int YAW_QUARTER  = 23040;
    localparam int YAW_3QUARTER = 69120;
    localparam int PITCH_LIMIT  = 22784;
    localparam int ONE_Q14      = 16384;
    localparam int CORDIC_K     = 163008219;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] pointer_x;
        logic signed [15:0] pointer_y;
        logic signed [7:0]  wheel_step;
        logic [15:0]        time_step;
        logic               key_ahead;
        logic               key_back;
        logic               key_left;
        logic               key_right;
        logic               key_boost;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] ahead_x;
        logic signed [15:0] ahead_y;
        logic signed [15:0] ahead_z;
        logic signed [15:0] side_x;
        logic signed [15:0] side_z;
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic signed [31:0] look_z;
        logic               drift_on;
    } t_out_item;

    // Arctangent of 2^-i in 1/65536 degree.
    function automatic logic [21:0] atan_ang(input logic [4:0] i);
        logic [21:0] r;
        case (i)
            5'd0:  r = 22'd2949120;
            5'd1:  r = 22'd1740967;
            5'd2:  r = 22'd919879;
            5'd3:  r = 22'd466945;
            5'd4:  r = 22'd234379;
            5'd5:  r = 22'd117304;
            5'd6:  r = 22'd58666;
            5'd7:  r = 22'd29335;
            5'd8:  r = 22'd14668;
            5'd9:  r = 22'd7334;
            5'd10: r = 22'd3667;
            5'd11: r = 22'd1833;
            5'd12: r = 22'd917;
            5'd13: r = 22'd458;
            5'd14: r = 22'd229;
            5'd15: r = 22'd115;
            5'd16: r = 22'd57;
            5'd17: r = 22'd29;
            5'd18: r = 22'd14;
            5'd19: r = 22'd7;
            5'd20: r = 22'd4;
            5'd21: r = 22'd2;
            5'd22: r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ffcam_in_if.sv
// Interface: input event channel of the camera block.
`default_nettype none
interface ffcam_in_if;
    import ffcam_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/ffcam_out_if.sv
// Interface: result channel of the camera block.
`default_nettype none
interface ffcam_out_if;
    import ffcam_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/free_fly_camera_update.sv
// Top level: free-fly camera state, iterative CORDIC and shared multiplier sequencer.
// A pointer event goes through the yaw reduction (11 steps) and two passes through the one
// CORDIC stage. A tick sends ten position terms through the shared multiplier; a wheel or
// unused event goes straight to the result. The input is ready again as soon as the result
// is loaded, and a stalled result holds the sequencer in its last state. Reset (synchronous,
// active low) restores the configuration defaults, zero position and angles, forward (1,0,0),
// right (0,0,-1), no result.
`default_nettype none
module free_fly_camera_update #(
    parameter int CORDIC_STAGES = ffcam_pkg::CORDIC_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffcam_in_if.sink    i_in,
    ffcam_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import ffcam_pkg::*;

    localparam int CW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_YMUL  = 5'd1;
    localparam logic [4:0] ST_YADD  = 5'd2;
    localparam logic [4:0] ST_YMOD  = 5'd3;
    localparam logic [4:0] ST_PMUL  = 5'd4;
    localparam logic [4:0] ST_PSET  = 5'd5;
    localparam logic [4:0] ST_CORD  = 5'd6;
    localparam logic [4:0] ST_CFIN  = 5'd7;
    localparam logic [4:0] ST_FMUL0 = 5'd8;
    localparam logic [4:0] ST_FMUL1 = 5'd9;
    localparam logic [4:0] ST_FSET  = 5'd10;
    localparam logic [4:0] ST_SMUL  = 5'd11;
    localparam logic [4:0] ST_SSET  = 5'd12;
    localparam logic [4:0] ST_TMUL  = 5'd13;
    localparam logic [4:0] ST_TADD  = 5'd14;
    localparam logic [4:0] ST_DRIFT = 5'd15;
    localparam logic [4:0] ST_DONE  = 5'd16;

    localparam logic [27:0] YAW_MOD   = 28'(YAW_FULL);
    localparam logic [29:0] YAW_WRAP  = 30'(YAW_FULL * 1024);
    localparam logic [3:0]  MOD_STEPS = 4'd10;
    localparam logic [3:0]  LAST_TERM = 4'd9;

    // Round half up by 14 bits and clamp to one in Q1.14.
    function automatic logic signed [15:0] rnd_clamp(input logic signed [48:0] v);
        logic signed [48:0] t;
        t = (v + 49'sd8192) >>> 14;
        if (t > 49'sd16384) return 16'sd16384;
        if (t < -49'sd16384) return -16'sd16384;
        return 16'(t);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        if (v > 37'sh07FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -37'sh080000000) return 32'sh80000000;
        return 32'(v);
    endfunction

    logic [4:0]         r_state;
    t_in_item           r_item;
    logic [11:0]        r_speed;
    logic [9:0]         r_gain;
    logic [15:0]        r_hold;
    logic signed [31:0] r_px, r_py, r_pz;
    logic [16:0]        r_yaw;
    logic signed [15:0] r_pitch;
    logic signed [15:0] r_fx, r_fy, r_fz, r_rx, r_rz;
    logic signed [15:0] r_lx, r_ly;
    logic               r_dact, r_ddown;
    logic [15:0]        r_dleft;
    logic signed [48:0] r_prod;
    logic [27:0]        r_acc;
    logic [3:0]         r_k;
    logic signed [31:0] r_cx, r_cy;
    logic signed [25:0] r_cz;
    logic [CW-1:0]      r_cnt;
    logic               r_pass, r_neg;
    logic signed [15:0] r_cyv, r_syv, r_cpv, r_spv;
    logic [29:0]        r_s;
    logic [3:0]         r_t;
    t_out_item          r_out;
    logic               r_oval;

    // Shared multiplier operand selection.
    logic signed [17:0] mul_a;
    logic signed [30:0] mul_b;
    logic signed [48:0] mul_p;
    logic signed [16:0] dx, dy;

    assign dx = 17'(r_item.pointer_x) - 17'(r_lx);
    assign dy = 17'(r_item.pointer_y) - 17'(r_ly);

    // Position term of a tick: axis, vector component, direction, key.
    logic signed [15:0] t_vec;
    logic [1:0]         t_axis;
    logic               t_sub, t_en;

    always_comb begin
        t_vec  = r_fx;
        t_axis = 2'd0;
        t_sub  = 1'b0;
        t_en   = 1'b0;
        case (r_t)
            4'd0: begin t_vec = r_fx; t_axis = 2'd0; t_en = r_item.key_ahead; end
            4'd1: begin t_vec = r_fy; t_axis = 2'd1; t_en = r_item.key_ahead; end
            4'd2: begin t_vec = r_fz; t_axis = 2'd2; t_en = r_item.key_ahead; end
            4'd3: begin t_vec = r_fx; t_axis = 2'd0; t_sub = 1'b1; t_en = r_item.key_back; end
            4'd4: begin t_vec = r_fy; t_axis = 2'd1; t_sub = 1'b1; t_en = r_item.key_back; end
            4'd5: begin t_vec = r_fz; t_axis = 2'd2; t_sub = 1'b1; t_en = r_item.key_back; end
            4'd6: begin t_vec = r_rx; t_axis = 2'd0; t_en = r_item.key_left; end
            4'd7: begin t_vec = r_rz; t_axis = 2'd2; t_en = r_item.key_left; end
            4'd8: begin t_vec = r_rx; t_axis = 2'd0; t_sub = 1'b1; t_en = r_item.key_right; end
            4'd9: begin t_vec = r_rz; t_axis = 2'd2; t_sub = 1'b1; t_en = r_item.key_right; end
            default: begin t_en = 1'b0; end
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_YMUL: begin mul_a = 18'(dx); mul_b = $signed({21'd0, r_gain}); end
            ST_PMUL: begin mul_a = 18'(dy); mul_b = $signed({21'd0, r_gain}); end
            ST_SMUL: begin
                mul_a = $signed({6'd0, r_speed});
                mul_b = $signed({15'd0, r_item.time_step});
            end
            ST_FMUL0: begin mul_a = 18'(r_cpv); mul_b = 31'(r_cyv); end
            ST_FMUL1: begin mul_a = 18'(r_cpv); mul_b = 31'(r_syv); end
            ST_TMUL:  begin mul_a = 18'(t_vec); mul_b = $signed({1'b0, r_s}); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = 49'(mul_a) * 49'(mul_b);

    // Yaw accumulation and pitch clamp.
    logic signed [29:0] yaw_sum, pitch_sum;
    logic signed [15:0] pitch_new;
    logic [27:0]        mod_m;

    assign yaw_sum   = $signed({13'd0, r_yaw}) + 30'(r_prod);
    assign pitch_sum = 30'(r_pitch) - 30'(r_prod);
    assign mod_m     = YAW_MOD << r_k;

    always_comb begin
        if (pitch_sum > 30'(PITCH_LIMIT)) pitch_new = 16'(PITCH_LIMIT);
        else if (pitch_sum < -30'(PITCH_LIMIT)) pitch_new = -16'(PITCH_LIMIT);
        else pitch_new = 16'(pitch_sum);
    end

    // Yaw folded into plus or minus 90 degrees.
    logic signed [17:0] yaw_fold;
    logic               yaw_neg;

    always_comb begin
        yaw_neg  = 1'b0;
        yaw_fold = $signed({1'b0, r_yaw});
        if (r_yaw > 17'(YAW_QUARTER) && r_yaw <= 17'(YAW_3QUARTER)) begin
            yaw_fold = $signed({1'b0, r_yaw}) - 18'(YAW_HALF);
            yaw_neg  = 1'b1;
        end else if (r_yaw > 17'(YAW_3QUARTER)) begin
            yaw_fold = $signed({1'b0, r_yaw}) - 18'(YAW_FULL);
        end
    end

    // One CORDIC rotation step.
    logic signed [31:0] xs, ys, cx_n, cy_n;
    logic signed [25:0] cz_n, at;
    logic signed [15:0] c_r, s_r;

    assign xs = r_cx >>> r_cnt;
    assign ys = r_cy >>> r_cnt;
    assign at = $signed({4'd0, atan_ang(5'(r_cnt))});

    always_comb begin
        if (r_cz >= 0) begin
            cx_n = r_cx - ys; cy_n = r_cy + xs; cz_n = r_cz - at;
        end else begin
            cx_n = r_cx + ys; cy_n = r_cy - xs; cz_n = r_cz + at;
        end
    end

    assign c_r = rnd_clamp(49'(r_cx));
    assign s_r = rnd_clamp(49'(r_cy));

    // Position term and drift arithmetic.
    logic signed [36:0] t_d, t_pos, t_sum, s_ext;
    assign t_d   = 37'((r_prod + 49'sd8192) >>> 14);
    assign t_pos = (t_axis == 2'd0) ? 37'(r_px) : (t_axis == 2'd1) ? 37'(r_py) : 37'(r_pz);
    assign t_sum = t_sub ? t_pos - t_d : t_pos + t_d;
    assign s_ext = $signed({7'd0, r_s});

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_oval;
    assign o_out.data  = r_out;

    // Sequencer and state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_speed <= SPEED_RST;
            r_gain  <= GAIN_RST;
            r_hold  <= HOLD_RST;
            r_px    <= '0;
            r_py    <= '0;
            r_pz    <= '0;
            r_yaw   <= '0;
            r_pitch <= '0;
            r_fx    <= 16'(ONE_Q14);
            r_fy    <= '0;
            r_fz    <= '0;
            r_rx    <= '0;
            r_rz    <= -16'(ONE_Q14);
            r_lx    <= '0;
            r_ly    <= '0;
            r_dact  <= 1'b0;
            r_ddown <= 1'b0;
            r_dleft <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MOVE_SPEED: r_speed <= i_cfg_data[11:0];
                    CFG_MOUSE_GAIN: r_gain  <= i_cfg_data[9:0];
                    CFG_DRIFT_HOLD: r_hold  <= i_cfg_data;
                    default: ;
                endcase
            end
            // The result beat leaves; the last state loads the next one itself.
            if (o_out.ready && r_state != ST_DONE) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_item <= i_in.data;
                        case (i_in.data.command)
                            CMD_POINTER: r_state <= ST_YMUL;
                            CMD_TICK:    r_state <= ST_SMUL;
                            CMD_WHEEL: begin
                                if (i_in.data.wheel_step != 8'sd0) begin
                                    r_dact  <= 1'b1;
                                    r_dleft <= r_hold;
                                    r_ddown <= i_in.data.wheel_step[7];
                                end
                                r_state <= ST_DONE;
                            end
                            default: r_state <= ST_DONE;
                        endcase
                    end
                end
                ST_YMUL: begin
                    r_prod  <= mul_p;
                    r_state <= ST_YADD;
                end
                ST_YADD: begin
                    r_acc   <= (yaw_sum < 0) ? 28'(yaw_sum + $signed(YAW_WRAP))
                                             : 28'(yaw_sum);
                    r_k     <= MOD_STEPS;
                    r_state <= ST_YMOD;
                end
                ST_YMOD: begin
                    // Restoring reduction by 92160 shifted down one place a step.
                    if (r_acc >= mod_m) begin
                        r_acc <= r_acc - mod_m;
                    end
                    if (r_k == 4'd0) begin
                        r_yaw   <= (r_acc >= mod_m) ? 17'(r_acc - mod_m) : 17'(r_acc);
                        r_state <= ST_PMUL;
                    end else begin
                        r_k <= r_k - 4'd1;
                    end
                end
                ST_PMUL: begin
                    r_prod  <= mul_p;
                    r_state <= ST_PSET;
                end
                ST_PSET: begin
                    r_pitch <= pitch_new;
                    r_lx    <= r_item.pointer_x;
                    r_ly    <= r_item.pointer_y;
                    r_cx    <= 32'(CORDIC_K);
                    r_cy    <= '0;
                    r_cz    <= 26'(yaw_fold) <<< 8;
                    r_neg   <= yaw_neg;
                    r_pass  <= 1'b0;
                    r_cnt   <= '0;
                    r_state <= ST_CORD;
                end
                ST_CORD: begin
                    r_cx <= cx_n;
                    r_cy <= cy_n;
                    r_cz <= cz_n;
                    if (r_cnt == CW'(CORDIC_STAGES - 1)) begin
                        r_state <= ST_CFIN;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                ST_CFIN: begin
                    if (!r_pass) begin
                        r_cyv   <= r_neg ? -c_r : c_r;
                        r_syv   <= r_neg ? -s_r : s_r;
                        r_cx    <= 32'(CORDIC_K);
                        r_cy    <= '0;
                        r_cz    <= 26'(r_pitch) <<< 8;
                        r_pass  <= 1'b1;
                        r_cnt   <= '0;
                        r_state <= ST_CORD;
                    end else begin
                        r_cpv   <= c_r;
                        r_spv   <= s_r;
                        r_state <= ST_FMUL0;
                    end
                end
                ST_FMUL0: begin
                    r_prod  <= mul_p;
                    r_state <= ST_FMUL1;
                end
                ST_FMUL1: begin
                    r_fx    <= rnd_clamp(r_prod);
                    r_prod  <= mul_p;
                    r_state <= ST_FSET;
                end
                ST_FSET: begin
                    r_fz    <= rnd_clamp(r_prod);
                    r_fy    <= r_spv;
                    r_rx    <= r_syv;
                    r_rz    <= -r_cyv;
                    r_state <= ST_DONE;
                end
                ST_SMUL: begin
                    r_prod  <= mul_p;
                    r_state <= ST_SSET;
                end
                ST_SSET: begin
                    r_s     <= r_item.key_boost ? 30'(r_prod) << 1 : 30'(r_prod);
                    r_t     <= '0;
                    r_state <= ST_TMUL;
                end
                ST_TMUL: begin
                    r_prod  <= mul_p;
                    r_state <= ST_TADD;
                end
                ST_TADD: begin
                    if (t_en) begin
                        case (t_axis)
                            2'd0:    r_px <= sat32(t_sum);
                            2'd1:    r_py <= sat32(t_sum);
                            default: r_pz <= sat32(t_sum);
                        endcase
                    end
                    if (r_t == LAST_TERM) begin
                        r_state <= ST_DRIFT;
                    end else begin
                        r_t     <= r_t + 4'd1;
                        r_state <= ST_TMUL;
                    end
                end
                ST_DRIFT: begin
                    // The drift still moves on the tick in which its timer runs out.
                    if (r_dact) begin
                        if (r_item.time_step > r_dleft) r_dact <= 1'b0;
                        else r_dleft <= r_dleft - r_item.time_step;
                        r_py <= sat32(r_ddown ? 37'(r_py) - s_ext : 37'(r_py) + s_ext);
                    end
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_oval || o_out.ready) begin
                        r_oval  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Result register, loaded as the sequencer leaves its last state.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_oval || o_out.ready)) begin
            r_out.pos_x    <= r_px;
            r_out.pos_y    <= r_py;
            r_out.pos_z    <= r_pz;
            r_out.ahead_x  <= r_fx;
            r_out.ahead_y  <= r_fy;
            r_out.ahead_z  <= r_fz;
            r_out.side_x   <= r_rx;
            r_out.side_z   <= r_rz;
            r_out.look_x   <= sat32(37'(r_px) + (37'(r_fx) <<< 2));
            r_out.look_y   <= sat32(37'(r_py) + (37'(r_fy) <<< 2));
            r_out.look_z   <= sat32(37'(r_pz) + (37'(r_fz) <<< 2));
            r_out.drift_on <= r_dact;
        end
    end

    // Checks on the sequencer and the held angles.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != ST_IDLE))
        else $error("sequencer idle right after accepting an event");
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_yaw < 17'(YAW_FULL))
        else $error("yaw outside one turn");
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pitch <= 16'(PITCH_LIMIT)) && (r_pitch >= -16'(PITCH_LIMIT)))
        else $error("pitch beyond its limit");
    a_ahead_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fx <= 16'(ONE_Q14)) && (r_fx >= -16'(ONE_Q14)) &&
        (r_fz <= 16'(ONE_Q14)) && (r_fz >= -16'(ONE_Q14)))
        else $error("forward vector component beyond one");

endmodule
`default_nettype wire
